// ===== rtl/fgcc_pkg.sv =====
// shared types and constants of the footprint grid collision checker
// no dependencies; imported by every module of the block
package fgcc_pkg;

   localparam int IDX_W   = 12;   // widest cell index field carried between modules
   localparam int CELL_W  = 14;   // integer bits of a sample position
   localparam int ANGLE_W = 12;
   localparam int STEP_W  = 8;
   localparam int GRID_W  = 10;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_STAMP = 2'd1;
   localparam logic [1:0] KIND_CHECK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_L = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_W = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_L  = 3'd4;

   typedef enum logic [1:0] {
      OP_RESTORE = 2'd0,
      OP_STAMP   = 2'd1,
      OP_CHECK   = 2'd2
   } op_type;

   typedef struct packed {
      logic             vld;
      op_type           op;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] row;
   } sample_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] row;
      logic             val;
   } cell_wr_type;

   // sine of a*(pi/2)/1024 in Q(tb), odd series on the quarter wave; elaboration only
   function automatic logic [63:0] quarter_sine(input int unsigned a, input int unsigned tb);
      logic [63:0] one;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      one = 64'd1 << 30;
      x   = 64'(a) * 64'd1647099;
      x2  = (x * x) >> 30;
      t   = one;
      t   = one - ((x2 * t) >> 30) / 64'd156;
      t   = one - ((x2 * t) >> 30) / 64'd110;
      t   = one - ((x2 * t) >> 30) / 64'd72;
      t   = one - ((x2 * t) >> 30) / 64'd42;
      t   = one - ((x2 * t) >> 30) / 64'd20;
      t   = one - ((x2 * t) >> 30) / 64'd6;
      t   = (x * t) >> 30;
      t   = (t + (64'd1 << (29 - tb))) >> (30 - tb);
      return t;
   endfunction

endpackage

// ===== rtl/footprint_grid_collision_check_core.sv =====
// top level of the footprint grid collision checker: control, registers, setup math
// depends on fgcc_pkg, fgcc_trig_rom, fgcc_sweep, fgcc_map
//
// channel   ports                                     handshake
// request   start, busy, req_*                        transfer when start && !busy
// response  rsp_valid, rsp_feasible                   one-cycle strobe, no back-pressure
// config    csr_valid, csr_ready, csr_index, csr_wdata transfer when valid && ready
//
// cell write and unused kind: the transfer leads from idle straight to the response state
// footprint check: body_width * body_length samples, one map read per sample
// obstacle stamp: body_width * extended length samples for each footprint walked;
//    the previous footprint is written back from the base map before the new one is marked
// synchronous active-high reset; map contents are not cleared
// the response cannot be stalled; busy stays high until the response cycle ends
module footprint_grid_collision_check_core
   import fgcc_pkg::*;
#(
   parameter int MAP_COLS  = 512,
   parameter int MAP_ROWS  = 512,
   parameter int TRIG_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_kind,
   input  logic signed [17:0]   req_pos_x,
   input  logic signed [17:0]   req_pos_y,
   input  logic [11:0]          req_heading,
   input  logic [8:0]           req_cell_col,
   input  logic [8:0]           req_cell_row,
   input  logic                 req_cell_value,
   output logic                 rsp_valid,
   output logic                 rsp_feasible,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [9:0]           csr_wdata
);
   localparam int TW = TRIG_BITS + 2;   // signed sine/cosine
   localparam int PW = TRIG_BITS + 22;  // signed sample position, 8+TRIG_BITS fraction bits
   localparam int MW = TW + STEP_W + 1; // step count times trig value

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_TRIG_S  = 11'b000_0000_0010,
      ST_TRIG_C  = 11'b000_0000_0100,
      ST_TRIG_W  = 11'b000_0000_1000,
      ST_MULT_X  = 11'b000_0001_0000,
      ST_MULT_Y  = 11'b000_0010_0000,
      ST_CORNER  = 11'b000_0100_0000,
      ST_RESTORE = 11'b000_1000_0000,
      ST_STAMP   = 11'b001_0000_0000,
      ST_CHECK   = 11'b010_0000_0000,
      ST_RESP    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [GRID_W-1:0] width_ff, height_ff;
   logic [STEP_W-1:0] body_l_ff, body_w_ff, ext_l_ff;

   // item registers
   logic [1:0]            kind_ff;
   logic signed [17:0]    px_ff, py_ff;
   logic [ANGLE_W-1:0]    head_ff;
   logic signed [TW-1:0]  sin_ff, cos_ff;
   logic signed [MW-1:0]  pa_ff, pb_ff;
   logic signed [PW-1:0]  cx_ff, cy_ff;

   // footprint of the last stamp, needed to undo it
   logic                  have_ff;
   logic signed [PW-1:0]  sv_cx_ff, sv_cy_ff;
   logic signed [TW-1:0]  sv_cos_ff, sv_sin_ff;
   logic [STEP_W-1:0]     sv_ww_ff, sv_len_ff;
   logic [GRID_W-1:0]     sv_gw_ff, sv_gh_ff;

   logic [GRID_W-1:0]     grid_w, grid_h;
   logic [ANGLE_W-1:0]    rom_angle;
   logic signed [TW-1:0]  rom_value;

   logic                  accept;
   logic                  sw_start, sw_busy, map_busy, hit, hit_clr, idle_pipe;
   op_type                sw_op;
   logic signed [PW-1:0]  sw_cx, sw_cy;
   logic signed [TW-1:0]  sw_cos, sw_sin;
   logic [STEP_W-1:0]     sw_ww, sw_len;
   logic [GRID_W-1:0]     sw_gw, sw_gh;
   sample_type            smp;
   cell_wr_type           cell_wr;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // grid in use never exceeds the map
   assign grid_w = (32'(width_ff) < MAP_COLS) ? width_ff : GRID_W'(MAP_COLS);
   assign grid_h = (32'(height_ff) < MAP_ROWS) ? height_ff : GRID_W'(MAP_ROWS);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 10'd380;
         height_ff <= 10'd330;
         body_l_ff <= 8'd50;
         body_w_ff <= 8'd20;
         ext_l_ff  <= 8'd55;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_BODY_L: body_l_ff <= csr_wdata[STEP_W-1:0];
            CSR_BODY_W: body_w_ff <= csr_wdata[STEP_W-1:0];
            CSR_EXT_L:  ext_l_ff  <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // cell write goes straight to both maps at the request transfer
   always_comb begin
      cell_wr.en  = accept && (req_kind == KIND_WRITE) &&
                    (32'(req_cell_col) < MAP_COLS) && (32'(req_cell_row) < MAP_ROWS);
      cell_wr.col = IDX_W'(req_cell_col);
      cell_wr.row = IDX_W'(req_cell_row);
      cell_wr.val = req_cell_value;
   end

   // sine first, then cosine a quarter turn ahead
   assign rom_angle = (state_ff == ST_TRIG_S) ? head_ff : head_ff + ANGLE_W'(1024);

   fgcc_trig_rom #(.TRIG_BITS(TRIG_BITS)) u_trig (
      .clock (clock),
      .angle (rom_angle),
      .value (rom_value)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         head_ff <= req_heading;
      end
      if (state_ff == ST_TRIG_C) begin
         sin_ff <= rom_value;
      end
      if (state_ff == ST_TRIG_W) begin
         cos_ff <= rom_value;
      end
      // rear corner: pose minus half length along heading, half width to the right
      if (state_ff == ST_MULT_X) begin
         pa_ff <= $signed({1'b0, body_l_ff}) * cos_ff;
         pb_ff <= $signed({1'b0, body_w_ff}) * sin_ff;
      end
      if (state_ff == ST_MULT_Y) begin
         cx_ff <= (PW'(px_ff) <<< TRIG_BITS) - (PW'(pa_ff) <<< 7) + (PW'(pb_ff) <<< 7);
         pa_ff <= $signed({1'b0, body_l_ff}) * sin_ff;
         pb_ff <= $signed({1'b0, body_w_ff}) * cos_ff;
      end
      if (state_ff == ST_CORNER) begin
         cy_ff <= (PW'(py_ff) <<< TRIG_BITS) - (PW'(pa_ff) <<< 7) - (PW'(pb_ff) <<< 7);
      end
   end

   assign idle_pipe = !sw_busy && !map_busy;

   // hit clear at the corner state, plus launch and operation helpers that the sweep does not use
   always_comb begin
      sw_start = 1'b0;
      sw_op    = OP_CHECK;
      hit_clr  = 1'b0;
      if (state_ff == ST_CORNER) begin
         // corner register loads this cycle; launch comes from the restore/stamp/check states
         hit_clr = 1'b1;
      end
      if (state_ff == ST_RESTORE && idle_pipe) begin
         sw_start = 1'b1;
         sw_op    = OP_STAMP;
      end
      if (state_ff == ST_TRIG_W) begin
         sw_op = OP_CHECK;
      end
      if (state_in != state_ff && state_in == ST_CHECK) begin
         sw_start = 1'b1;
         sw_op    = OP_CHECK;
      end
      if (state_ff == ST_CORNER && state_in == ST_RESTORE) begin
         sw_start = 1'b0;
      end
   end

   // restore uses the saved footprint, the others the current one
   logic launch_restore_ff;
   logic launch_ff;

   always_comb begin
      if (launch_restore_ff) begin
         sw_cx  = sv_cx_ff;
         sw_cy  = sv_cy_ff;
         sw_cos = sv_cos_ff;
         sw_sin = sv_sin_ff;
         sw_ww  = sv_ww_ff;
         sw_len = sv_len_ff;
         sw_gw  = sv_gw_ff;
         sw_gh  = sv_gh_ff;
      end else begin
         sw_cx  = cx_ff;
         sw_cy  = cy_ff;
         sw_cos = cos_ff;
         sw_sin = sin_ff;
         sw_ww  = body_w_ff;
         sw_len = (kind_ff == KIND_STAMP) ? ext_l_ff : body_l_ff;
         sw_gw  = grid_w;
         sw_gh  = grid_h;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_kind == KIND_STAMP || req_kind == KIND_CHECK) ? ST_TRIG_S
                                                                              : ST_RESP;
            end
         end
         ST_TRIG_S: state_in = ST_TRIG_C;
         ST_TRIG_C: state_in = ST_TRIG_W;
         ST_TRIG_W: state_in = ST_MULT_X;
         ST_MULT_X: state_in = ST_MULT_Y;
         ST_MULT_Y: state_in = ST_CORNER;
         ST_CORNER: begin
            if (kind_ff == KIND_CHECK) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_RESTORE;
            end
         end
         ST_RESTORE: begin
            if (idle_pipe && !launch_ff) begin
               state_in = ST_STAMP;
            end
         end
         ST_STAMP: begin
            if (idle_pipe && !launch_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_CHECK: begin
            if (idle_pipe && !launch_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // launch_ff marks the first cycle of a sweep state, before the walker reports busy
   logic             go_start;
   op_type           go_op;

   always_comb begin
      go_start = 1'b0;
      go_op    = OP_CHECK;
      if (state_ff == ST_CORNER) begin
         go_start = 1'b0;
      end
      if (launch_ff) begin
         go_start = 1'b1;
         case (state_ff)
            ST_RESTORE: go_op = launch_restore_ff ? OP_RESTORE : OP_STAMP;
            ST_STAMP:   go_op = OP_STAMP;
            ST_CHECK:   go_op = OP_CHECK;
            default:    go_op = OP_CHECK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         launch_ff         <= 1'b0;
         launch_restore_ff <= 1'b0;
         have_ff           <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= (state_in != state_ff) &&
                      (state_in == ST_RESTORE || state_in == ST_STAMP || state_in == ST_CHECK);
         if (state_ff == ST_CORNER) begin
            launch_restore_ff <= (kind_ff == KIND_STAMP) && have_ff;
         end else if (state_ff == ST_RESTORE && state_in == ST_STAMP) begin
            launch_restore_ff <= 1'b0;
         end
         if (state_ff == ST_STAMP && launch_ff) begin
            have_ff <= 1'b1;
         end
      end
   end

   // keep the stamped footprint for the next stamp
   always_ff @(posedge clock) begin
      if (state_ff == ST_STAMP && launch_ff) begin
         sv_cx_ff  <= cx_ff;
         sv_cy_ff  <= cy_ff;
         sv_cos_ff <= cos_ff;
         sv_sin_ff <= sin_ff;
         sv_ww_ff  <= body_w_ff;
         sv_len_ff <= ext_l_ff;
         sv_gw_ff  <= grid_w;
         sv_gh_ff  <= grid_h;
      end
   end

   fgcc_sweep #(.TRIG_BITS(TRIG_BITS)) u_sweep (
      .clock       (clock),
      .reset       (reset),
      .start       (go_start),
      .op          (go_op),
      .cx          (sw_cx),
      .cy          (sw_cy),
      .cos_v       (sw_cos),
      .sin_v       (sw_sin),
      .width_steps (sw_ww),
      .len_steps   (sw_len),
      .grid_w      (sw_gw),
      .grid_h      (sw_gh),
      .smp         (smp),
      .busy        (sw_busy)
   );

   fgcc_map #(.MAP_COLS(MAP_COLS), .MAP_ROWS(MAP_ROWS)) u_map (
      .clock   (clock),
      .reset   (reset),
      .smp     (smp),
      .wr      (cell_wr),
      .hit_clr (hit_clr),
      .hit     (hit),
      .busy    (map_busy)
   );

   assign rsp_valid    = (state_ff == ST_RESP);
   assign rsp_feasible = rsp_valid && (kind_ff == KIND_CHECK) && !hit;

   // unused launch helpers from the selection block
   logic unused_sel;
   assign unused_sel = sw_start ^ (sw_op == OP_CHECK);

   a_rsp_pulse : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not raise busy");

   a_sweep_in_sweep_state : assert property (@(posedge clock) disable iff (reset)
      sw_busy |-> (state_ff == ST_RESTORE || state_ff == ST_STAMP || state_ff == ST_CHECK))
      else $error("walker active outside a sweep state");

   a_feasible_only_check : assert property (@(posedge clock) disable iff (reset)
      rsp_feasible |-> (rsp_valid && kind_ff == KIND_CHECK))
      else $error("feasible reported for a non-check request");

endmodule

// ===== rtl/fgcc_trig_rom.sv =====
// sine table with registered read, quarter wave folded to a full turn
// depends on fgcc_pkg
module fgcc_trig_rom
   import fgcc_pkg::*;
#(
   parameter int TRIG_BITS = 12
) (
   input  logic                       clock,
   input  logic [ANGLE_W-1:0]         angle,
   output logic signed [TRIG_BITS+1:0] value
);
   localparam int QDEPTH = 1025;
   localparam int QA_W   = $clog2(QDEPTH);

   logic [TRIG_BITS:0] qtab [0:QDEPTH-1];
   logic [QA_W-1:0]    qidx;
   logic [TRIG_BITS:0] mag_ff;
   logic               neg_ff;

   for (genvar g = 0; g < QDEPTH; g++) begin : g_tab
      assign qtab[g] = (TRIG_BITS+1)'(quarter_sine(g, TRIG_BITS));
   end

   // odd quadrants mirror the quarter wave
   assign qidx = angle[ANGLE_W-2] ? (QA_W'(QDEPTH - 1) - QA_W'(angle[ANGLE_W-3:0]))
                                  : QA_W'(angle[ANGLE_W-3:0]);

   always_ff @(posedge clock) begin
      mag_ff <= qtab[qidx];
      neg_ff <= angle[ANGLE_W-1];
   end

   assign value = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});

endmodule

// ===== rtl/fgcc_sweep.sv =====
// footprint lattice walker: one sample per cycle, converted to in-grid cell indices
// depends on fgcc_pkg
module fgcc_sweep
   import fgcc_pkg::*;
#(
   parameter int TRIG_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  op_type                      op,
   input  logic signed [TRIG_BITS+21:0] cx,
   input  logic signed [TRIG_BITS+21:0] cy,
   input  logic signed [TRIG_BITS+1:0] cos_v,
   input  logic signed [TRIG_BITS+1:0] sin_v,
   input  logic [STEP_W-1:0]           width_steps,
   input  logic [STEP_W-1:0]           len_steps,
   input  logic [GRID_W-1:0]           grid_w,
   input  logic [GRID_W-1:0]           grid_h,
   output sample_type                  smp,
   output logic                        busy
);
   localparam int PW = TRIG_BITS + 22;
   localparam int FB = TRIG_BITS + 8;

   logic                 run_ff;
   op_type               op_ff;
   logic signed [PW-1:0] rx_ff, ry_ff, sx_ff, sy_ff;
   logic signed [PW-1:0] dc_ff, ds_ff;
   logic [STEP_W-1:0]    i_ff, j_ff, ww_ff, len_ff;
   logic [GRID_W-1:0]    gw_ff, gh_ff;
   sample_type           smp_ff;

   logic signed [PW-1:0] nrx, nry, ny;
   logic [PW-1:0]        xmag, ymag;
   logic [CELL_W-1:0]    cm, rm;
   logic                 x_ok, y_ok;

   assign nrx = rx_ff - ds_ff;
   assign nry = ry_ff + dc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= (width_steps != '0) && (len_steps != '0);
      end else if (run_ff && (j_ff == len_ff - 1'b1) && (i_ff == ww_ff - 1'b1)) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff  <= op;
         rx_ff  <= cx;
         ry_ff  <= cy;
         sx_ff  <= cx;
         sy_ff  <= cy;
         dc_ff  <= PW'(cos_v) <<< 8;
         ds_ff  <= PW'(sin_v) <<< 8;
         i_ff   <= '0;
         j_ff   <= '0;
         ww_ff  <= width_steps;
         len_ff <= len_steps;
         gw_ff  <= grid_w;
         gh_ff  <= grid_h;
      end else if (run_ff) begin
         if (j_ff == len_ff - 1'b1) begin
            // next row across the heading
            j_ff  <= '0;
            i_ff  <= i_ff + 1'b1;
            rx_ff <= nrx;
            ry_ff <= nry;
            sx_ff <= nrx;
            sy_ff <= nry;
         end else begin
            j_ff  <= j_ff + 1'b1;
            sx_ff <= sx_ff + dc_ff;
            sy_ff <= sy_ff + ds_ff;
         end
      end
   end

   // truncation toward zero; row index is minus y
   assign ny   = -sy_ff;
   assign xmag = sx_ff[PW-1] ? PW'(-sx_ff) : PW'(sx_ff);
   assign ymag = ny[PW-1] ? PW'(-ny) : PW'(ny);
   assign cm   = xmag[PW-1:FB];
   assign rm   = ymag[PW-1:FB];
   assign x_ok = (!sx_ff[PW-1] || cm == '0) && (cm < CELL_W'(gw_ff));
   assign y_ok = (!ny[PW-1] || rm == '0) && (rm < CELL_W'(gh_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_ff.vld <= 1'b0;
      end else begin
         smp_ff.vld <= run_ff && x_ok && y_ok;
      end
      smp_ff.op  <= op_ff;
      smp_ff.col <= IDX_W'(cm);
      smp_ff.row <= IDX_W'(rm);
   end

   assign smp  = smp_ff;
   assign busy = run_ff | smp_ff.vld;

endmodule

// ===== rtl/fgcc_map.sv =====
// base and working bit maps with read-modify-write pipeline
// depends on fgcc_pkg
module fgcc_map
   import fgcc_pkg::*;
#(
   parameter int MAP_COLS = 512,
   parameter int MAP_ROWS = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  sample_type  smp,
   input  cell_wr_type wr,
   input  logic        hit_clr,
   output logic        hit,
   output logic        busy
);
   localparam int DEPTH = MAP_COLS * MAP_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAP_COLS);
   localparam int RW    = $clog2(MAP_ROWS);

   logic base_mem [0:DEPTH-1];
   logic work_mem [0:DEPTH-1];

   logic [AW-1:0] rd_addr, wr_addr, a2_ff, work_waddr;
   logic          base_rd_ff, work_rd_ff;
   logic          v2_ff;
   op_type        op2_ff;
   logic          hit_ff;
   logic          work_we, work_wd;

   assign rd_addr = AW'(smp.row[RW-1:0]) * AW'(MAP_COLS) + AW'(smp.col[CW-1:0]);
   assign wr_addr = AW'(wr.row[RW-1:0]) * AW'(MAP_COLS) + AW'(wr.col[CW-1:0]);

   // pipeline writes back restored or stamped cells; cell writes only come while idle
   always_comb begin
      work_we    = wr.en;
      work_wd    = wr.val;
      work_waddr = wr_addr;
      if (v2_ff && op2_ff == OP_RESTORE) begin
         work_we    = 1'b1;
         work_wd    = base_rd_ff;
         work_waddr = a2_ff;
      end else if (v2_ff && op2_ff == OP_STAMP) begin
         work_we    = 1'b1;
         work_wd    = 1'b1;
         work_waddr = a2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         base_mem[wr_addr] <= wr.val;
      end
      base_rd_ff <= base_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[work_waddr] <= work_wd;
      end
      work_rd_ff <= work_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         v2_ff <= smp.vld;
         if (hit_clr) begin
            hit_ff <= 1'b0;
         end else if (v2_ff && op2_ff == OP_CHECK && work_rd_ff) begin
            hit_ff <= 1'b1;
         end
      end
      op2_ff <= smp.op;
      a2_ff  <= rd_addr;
   end

   assign hit  = hit_ff;
   assign busy = v2_ff;

endmodule
